// ===== hw/rtl/hsc_pkg.sv =====
// Shared types, constants and code tables for the Hamming SEC codec.
package hsc_pkg;

    localparam int MAX_DATA   = 57;
    localparam int DATA_W     = 57;
    localparam int CODE_W     = 63;
    localparam int CODE_IDX_W = 6;
    localparam int POS_W      = 6;
    localparam int CHK_W      = 3;
    localparam int CHK_MAX    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DATA_LENGTH = 2'd0,
        REG_PARITY_ODD  = 2'd1
    } hsc_reg_idx_t;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } hsc_op_t;

    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] data_in;
        logic [CODE_W-1:0] code_in;
    } hsc_in_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_out;
        logic [DATA_W-1:0] data_out;
        logic [POS_W-1:0]  error_position;
        logic              position_invalid;
    } hsc_out_t;

    typedef struct packed {
        logic [POS_W-1:0] msg_len;
        logic [POS_W-1:0] code_len;
        logic [CHK_W-1:0] chk_bits;
        logic             parity_odd;
    } hsc_cfg_t;

    function automatic logic [POS_W-1:0] hsc_msg_len(input logic [CFG_DATA_W-1:0] v);
        logic [POS_W-1:0] m;
        if (v == '0) begin
            m = POS_W'(1);
        end else if (v > CFG_DATA_W'(MAX_DATA)) begin
            m = POS_W'(MAX_DATA);
        end else begin
            m = POS_W'(v);
        end
        return m;
    endfunction

    function automatic logic [CHK_W-1:0] hsc_chk_bits(input logic [POS_W-1:0] m);
        logic [CHK_W-1:0] r;
        r = '0;
        for (int i = 0; i < 7; i++) begin
            if ((8'd1 << r) < (8'(m) + 8'(r) + 8'd1)) begin
                r = r + CHK_W'(1);
            end
        end
        return r;
    endfunction

    function automatic logic [CODE_IDX_W-1:0] hsc_data_slot(input int j);
        int cnt;
        logic [CODE_IDX_W-1:0] slot;
        cnt  = 0;
        slot = '0;
        for (int p = 1; p <= CODE_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (cnt == j) begin
                    slot = CODE_IDX_W'(p - 1);
                end
                cnt++;
            end
        end
        return slot;
    endfunction

    function automatic logic [CODE_W-1:0] hsc_group_mask(input int k);
        logic [CODE_W-1:0] gm;
        for (int i = 0; i < CODE_W; i++) begin
            gm[i] = (((i + 1) >> k) & 1) != 0;
        end
        return gm;
    endfunction

endpackage

// ===== hw/rtl/hsc_cfg_regs.sv =====
// Configuration registers with the derived code geometry.
module hsc_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hsc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output hsc_pkg::hsc_cfg_t                cfg
);

    hsc_pkg::hsc_cfg_t cfg_reg;
    hsc_pkg::hsc_cfg_t cfg_next;
    logic [hsc_pkg::POS_W-1:0] m_new;
    logic [hsc_pkg::CHK_W-1:0] r_new;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        m_new    = hsc_pkg::hsc_msg_len(cfg_data);
        r_new    = hsc_pkg::hsc_chk_bits(m_new);
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                hsc_pkg::REG_DATA_LENGTH: begin
                    cfg_next.msg_len  = m_new;
                    cfg_next.chk_bits = r_new;
                    cfg_next.code_len = m_new + hsc_pkg::POS_W'(r_new);
                end
                hsc_pkg::REG_PARITY_ODD: begin
                    cfg_next.parity_odd = cfg_data[0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.msg_len    <= hsc_pkg::POS_W'(4);
            cfg_reg.chk_bits   <= hsc_pkg::CHK_W'(3);
            cfg_reg.code_len   <= hsc_pkg::POS_W'(7);
            cfg_reg.parity_odd <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/hsc_core.sv =====
// Encode and decode datapath: scatter, parity trees, correction and gather.
module hsc_core (
    input  hsc_pkg::hsc_cfg_t  cfg,
    input  hsc_pkg::hsc_in_t   in_word,
    output hsc_pkg::hsc_out_t  out_word
);

    logic [hsc_pkg::CODE_W-1:0] len_mask;
    logic [hsc_pkg::DATA_W-1:0] msg_mask;
    logic [hsc_pkg::DATA_W-1:0] data_m;
    logic [hsc_pkg::CODE_W-1:0] enc_word;
    logic [hsc_pkg::CODE_W-1:0] rx_word;
    logic [hsc_pkg::CODE_W-1:0] flip;
    logic [hsc_pkg::CODE_W-1:0] fixed_word;
    logic [hsc_pkg::DATA_W-1:0] dec_data;
    logic [hsc_pkg::POS_W-1:0]  syn;
    logic                       bad;

    always_comb begin
        for (int i = 0; i < hsc_pkg::CODE_W; i++) begin
            len_mask[i] = hsc_pkg::POS_W'(i) < cfg.code_len;
        end
        for (int j = 0; j < hsc_pkg::DATA_W; j++) begin
            msg_mask[j] = hsc_pkg::POS_W'(j) < cfg.msg_len;
        end
        data_m = in_word.data_in & msg_mask;

        enc_word = '0;
        for (int j = 0; j < hsc_pkg::DATA_W; j++) begin
            enc_word[hsc_pkg::hsc_data_slot(j)] = data_m[j];
        end
        for (int k = 0; k < hsc_pkg::CHK_MAX; k++) begin
            if (hsc_pkg::CHK_W'(k) < cfg.chk_bits) begin
                enc_word[hsc_pkg::CODE_IDX_W'((1 << k) - 1)] =
                    (^(enc_word & hsc_pkg::hsc_group_mask(k))) ^ cfg.parity_odd;
            end
        end

        rx_word = in_word.code_in & len_mask;
        syn     = '0;
        for (int k = 0; k < hsc_pkg::CHK_MAX; k++) begin
            syn[k] = (hsc_pkg::CHK_W'(k) < cfg.chk_bits) &&
                     (((^(rx_word & hsc_pkg::hsc_group_mask(k))) ^ cfg.parity_odd) != 1'b0);
        end
        bad = syn > cfg.code_len;
        for (int i = 0; i < hsc_pkg::CODE_W; i++) begin
            flip[i] = !bad && (syn == hsc_pkg::POS_W'(i + 1));
        end
        fixed_word = rx_word ^ flip;
        for (int j = 0; j < hsc_pkg::DATA_W; j++) begin
            dec_data[j] = fixed_word[hsc_pkg::hsc_data_slot(j)];
        end

        case (in_word.op)
            hsc_pkg::OP_ENCODE: begin
                out_word.code_out         = enc_word;
                out_word.data_out         = data_m;
                out_word.error_position   = '0;
                out_word.position_invalid = 1'b0;
            end
            hsc_pkg::OP_DECODE: begin
                out_word.code_out         = fixed_word;
                out_word.data_out         = dec_data;
                out_word.error_position   = syn;
                out_word.position_invalid = bad;
            end
            default: begin
                out_word = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/hamming_sec_codec.sv =====
// Top level of the Hamming SEC codec: input register, datapath, result register.
// An accepted word passes the input register, then the result register, before m_valid.
// Throughput: one word per cycle unless m_ready stalls; parity trees sit between them.
// A full result register stalled by m_ready holds the input register behind it.
// Reset (synchronous, aresetn low) empties both registers and loads data_length 4, even parity.
module hamming_sec_codec (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  hsc_pkg::hsc_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output hsc_pkg::hsc_out_t                m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    hsc_pkg::hsc_cfg_t cfg;
    hsc_pkg::hsc_in_t  in_data_reg;
    hsc_pkg::hsc_out_t out_data_reg;
    hsc_pkg::hsc_out_t core_out;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_load;
    logic              in_load;

    hsc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hsc_core u_core (
        .cfg      (cfg),
        .in_word  (in_data_reg),
        .out_word (core_out)
    );

    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_load) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_data_reg <= s_data;
        end
        if (out_load) begin
            out_data_reg <= core_out;
        end
    end

`ifndef SYNTH
    a_invalid_beyond_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.position_invalid) |-> (m_data.error_position > cfg.code_len))
        else $error("flagged syndrome lies inside the codeword");

    a_load_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> out_valid_reg)
        else $error("loaded result register is empty");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("input register lost a word while output stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!in_valid_reg && !out_valid_reg))
        else $error("pipeline not empty after reset");
`endif

endmodule

// ===== sim/hamming_sec_codec_tb.sv =====
// Self-checking testbench for hamming_sec_codec: random handshakes, scoreboard against a predictor.
module hamming_sec_codec_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [hsc_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [hsc_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int RAND_PHASES     = 17;
    localparam int WORDS_PER_PHASE = 50;

    class hamming_scoreboard;
        logic [hsc_pkg::CFG_DATA_W-1:0] dlen;
        logic                           odd_par;
        hsc_pkg::hsc_out_t              awaited[$];
        int                             failures;

        function new();
            dlen     = hsc_pkg::CFG_DATA_W'(4);
            odd_par  = 1'b0;
            failures = 0;
        endfunction

        function void write_reg(logic [hsc_pkg::CFG_IDX_W-1:0] idx,
                                logic [hsc_pkg::CFG_DATA_W-1:0] v);
            if (idx == hsc_pkg::REG_DATA_LENGTH) begin
                dlen = v;
            end else if (idx == hsc_pkg::REG_PARITY_ODD) begin
                odd_par = v[0];
            end
        endfunction

        function int msg_bits();
            int m;
            m = int'(dlen);
            if (m < 1) begin
                m = 1;
            end else if (m > hsc_pkg::MAX_DATA) begin
                m = hsc_pkg::MAX_DATA;
            end
            return m;
        endfunction

        function int parity_bits();
            int r;
            int m;
            m = msg_bits();
            r = 0;
            while ((1 << r) < m + r + 1) begin
                r++;
            end
            return r;
        endfunction

        function int code_len();
            return msg_bits() + parity_bits();
        endfunction

        function hsc_pkg::hsc_out_t predict(hsc_pkg::hsc_in_t w);
            hsc_pkg::hsc_out_t res;
            int          m;
            int          r;
            int          n;
            int          j;
            int          pos;
            int          k;
            int unsigned syn;
            logic [63:0] word;
            logic [63:0] data;
            logic        par;
            m    = msg_bits();
            r    = parity_bits();
            n    = m + r;
            word = '0;
            data = '0;
            syn  = 0;
            if (w.op == hsc_pkg::OP_ENCODE) begin
                data = {7'd0, w.data_in} & ((64'd1 << m) - 64'd1);
                j = 0;
                for (pos = 1; pos <= n; pos++) begin
                    if ((pos & (pos - 1)) != 0) begin
                        word[pos-1] = data[j];
                        j++;
                    end
                end
                for (k = 0; k < r; k++) begin
                    par = odd_par;
                    for (pos = 1; pos <= n; pos++) begin
                        if (((pos >> k) & 1) != 0) begin
                            par ^= word[pos-1];
                        end
                    end
                    word[(1 << k) - 1] = par;
                end
            end else begin
                word = {1'b0, w.code_in} & ((64'd1 << n) - 64'd1);
                for (k = 0; k < r; k++) begin
                    par = odd_par;
                    for (pos = 1; pos <= n; pos++) begin
                        if (((pos >> k) & 1) != 0) begin
                            par ^= word[pos-1];
                        end
                    end
                    if (par) begin
                        syn |= (1 << k);
                    end
                end
                if (syn != 0 && syn <= n) begin
                    word[syn-1] = ~word[syn-1];
                end
                j = 0;
                for (pos = 1; pos <= n; pos++) begin
                    if ((pos & (pos - 1)) != 0) begin
                        data[j] = word[pos-1];
                        j++;
                    end
                end
            end
            res.code_out         = word[hsc_pkg::CODE_W-1:0];
            res.data_out         = data[hsc_pkg::DATA_W-1:0];
            res.error_position   = syn[hsc_pkg::POS_W-1:0];
            res.position_invalid = (syn > n);
            return res;
        endfunction

        function void note(hsc_pkg::hsc_in_t w);
            awaited.push_back(predict(w));
        endfunction

        function void check(hsc_pkg::hsc_out_t got);
            hsc_pkg::hsc_out_t exp_res;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected result word: code %h data %h pos %0d inv %0b",
                             got.code_out, got.data_out, got.error_position,
                             got.position_invalid);
                end
                return;
            end
            exp_res = awaited.pop_front();
            if (got.code_out !== exp_res.code_out || got.data_out !== exp_res.data_out ||
                got.error_position !== exp_res.error_position ||
                got.position_invalid !== exp_res.position_invalid) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch: code exp %h got %h", exp_res.code_out, got.code_out);
                    $display("          data exp %h got %h", exp_res.data_out, got.data_out);
                    $display("          pos exp %0d got %0d, inv exp %0b got %0b",
                             exp_res.error_position, got.error_position,
                             exp_res.position_invalid, got.position_invalid);
                end
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    hsc_pkg::hsc_in_t               s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    hsc_pkg::hsc_out_t              m_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [hsc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [hsc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    hamming_scoreboard sb;
    int                gap_pct   = 0;
    int                stall_pct = 0;
    int                stall_left = 0;

    hamming_sec_codec dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note(s_data);
            end
            if (m_valid && m_ready) begin
                sb.check(m_data);
            end
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
            end
        end
    end

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) begin
                stall_left = idle_len();
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic hsc_pkg::hsc_in_t make_word(logic op,
                                                   logic [hsc_pkg::DATA_W-1:0] d,
                                                   logic [hsc_pkg::CODE_W-1:0] c);
        hsc_pkg::hsc_in_t w;
        w.op      = op;
        w.data_in = d;
        w.code_in = c;
        return w;
    endfunction

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_reg(input logic [hsc_pkg::CFG_IDX_W-1:0] idx,
                               input logic [hsc_pkg::CFG_DATA_W-1:0] v);
        wait_drained();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input hsc_pkg::hsc_in_t w);
        int gap;
        gap = ($urandom_range(0, 99) < gap_pct) ? idle_len() : 0;
        if (gap != 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random_word();
        hsc_pkg::hsc_in_t  w;
        hsc_pkg::hsc_out_t enc;
        logic [63:0] c;
        logic [63:0] cmask;
        int          n;
        int          sel;
        n     = sb.code_len();
        cmask = (64'd1 << n) - 64'd1;
        sel   = $urandom_range(0, 99);
        if (sel < 30) begin
            w = make_word(hsc_pkg::OP_ENCODE, hsc_pkg::DATA_W'(rand64()),
                          hsc_pkg::CODE_W'(rand64()));
        end else if (sel < 75) begin
            enc = sb.predict(make_word(hsc_pkg::OP_ENCODE, hsc_pkg::DATA_W'(rand64()), '0));
            c   = {1'b0, enc.code_out};
            sel = $urandom_range(0, 9);
            if (sel >= 4 && sel < 9) begin
                c[$urandom_range(0, n - 1)] ^= 1'b1;
            end else if (sel == 9) begin
                c[$urandom_range(0, hsc_pkg::CODE_W - 1)] ^= 1'b1;
            end
            if ($urandom_range(0, 1) == 1) begin
                c |= rand64() & ~cmask;
            end
            w = make_word(hsc_pkg::OP_DECODE, hsc_pkg::DATA_W'(rand64()),
                          c[hsc_pkg::CODE_W-1:0]);
        end else begin
            w = make_word(hsc_pkg::OP_DECODE, hsc_pkg::DATA_W'(rand64()),
                          hsc_pkg::CODE_W'(rand64()));
        end
        send_word(w);
    endtask

    initial begin
        logic [hsc_pkg::DATA_W-1:0] d_ones;
        logic [hsc_pkg::CODE_W-1:0] c_ones;
        int                ph;
        int                i;
        int                sel;
        logic [5:0]        len_val;
        sb     = new();
        d_ones = '1;
        c_ones = '1;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_word(make_word(hsc_pkg::OP_ENCODE, '0, c_ones));
        send_word(make_word(hsc_pkg::OP_ENCODE, d_ones, '0));
        send_word(make_word(hsc_pkg::OP_DECODE, d_ones, '0));
        send_word(make_word(hsc_pkg::OP_DECODE, '0, c_ones));
        send_word(make_word(hsc_pkg::OP_DECODE, '0, 63'h10));

        program_reg(hsc_pkg::REG_DATA_LENGTH, 6'd0);
        program_reg(hsc_pkg::REG_PARITY_ODD, 6'h3F);
        program_reg(REG_SPARE_2, 6'h3F);
        program_reg(REG_SPARE_3, 6'h3F);
        send_word(make_word(hsc_pkg::OP_ENCODE, d_ones, c_ones));
        send_word(make_word(hsc_pkg::OP_DECODE, '0, '0));
        send_word(make_word(hsc_pkg::OP_DECODE, d_ones, c_ones));

        program_reg(hsc_pkg::REG_DATA_LENGTH, 6'd63);
        program_reg(hsc_pkg::REG_PARITY_ODD, 6'd0);
        send_word(make_word(hsc_pkg::OP_ENCODE, d_ones, '0));
        send_word(make_word(hsc_pkg::OP_DECODE, '0, c_ones));
        send_word(make_word(hsc_pkg::OP_DECODE, '0, '0));

        program_reg(hsc_pkg::REG_DATA_LENGTH, 6'd57);
        program_reg(hsc_pkg::REG_PARITY_ODD, 6'd1);
        send_word(make_word(hsc_pkg::OP_ENCODE, '0, '0));
        send_word(make_word(hsc_pkg::OP_ENCODE, d_ones, '0));
        send_word(make_word(hsc_pkg::OP_DECODE, '0, c_ones));
        send_word(make_word(hsc_pkg::OP_DECODE, '0, 63'h4000_0000_0000_0000));

        program_reg(hsc_pkg::REG_DATA_LENGTH, 6'd5);
        program_reg(hsc_pkg::REG_PARITY_ODD, 6'd0);
        send_word(make_word(hsc_pkg::OP_DECODE, '0, 63'h88));
        send_word(make_word(hsc_pkg::OP_DECODE, '0, 63'hC0));
        send_word(make_word(hsc_pkg::OP_ENCODE, d_ones, c_ones));

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: begin
                    len_val = 6'd0;
                end
                1: begin
                    len_val = 6'd1;
                end
                2: begin
                    len_val = 6'd57;
                end
                3: begin
                    len_val = 6'd63;
                end
                default: begin
                    len_val = 6'($urandom_range(1, 63));
                end
            endcase
            program_reg(hsc_pkg::REG_DATA_LENGTH, len_val);
            program_reg(hsc_pkg::REG_PARITY_ODD, 6'($urandom));
            if ($urandom_range(0, 4) == 0) begin
                program_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                            6'($urandom));
            end
            if ($urandom_range(0, 3) == 0) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = $urandom_range(5, 50);
                stall_pct = $urandom_range(5, 50);
            end
            for (i = 0; i < WORDS_PER_PHASE; i++) begin
                if (ph == RAND_PHASES / 2 && i == WORDS_PER_PHASE / 2) begin
                    wait_drained();
                end
                send_random_word();
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/hsc_pkg.sv
hw/rtl/hsc_cfg_regs.sv
hw/rtl/hsc_core.sv
hw/rtl/hamming_sec_codec.sv
sim/hamming_sec_codec_tb.sv
